@@ rtl/nxa_pkg.sv @@
// Shared types and constants for the next-access annotator.
// Used by every design module of the block; depends on nothing else.
package nxa_pkg;

  // Default sizes of the trace store and the last-seen table.
  localparam int unsigned TraceDepthDef = 4096;
  localparam int unsigned NumBlocksDef  = 4096;

  // Field widths of the stream words.
  localparam int unsigned BlkW     = 12;
  localparam int unsigned PosW     = 12;
  localparam int unsigned NextW    = 14;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Width of the generation tag kept with each last-seen entry.
  localparam int unsigned EpochW = 8;

  // Action codes carried in the input tuser.
  localparam logic ActLoad  = 1'b0;
  localparam logic ActDrain = 1'b1;

  typedef enum logic [1:0] {
    StClear,
    StLoad,
    StScan,
    StDrain
  } nxa_state_e;

  // Strobes for the trace and next-access stores.
  typedef struct packed {
    logic trace_wr;
    logic next_wr;
    logic rd;
  } trace_ctl_t;

  // Strobes for the last-seen table.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } seen_ctl_t;

endpackage

@@ rtl/nxa_trace_store.sv @@
// Trace store and next-access store, one write and one shared read port each.
// Depends on nxa_pkg for field widths and the strobe struct.
module nxa_trace_store #(
  parameter int unsigned TRACE_DEPTH = nxa_pkg::TraceDepthDef
) (
  input  logic                                clk_i,
  input  nxa_pkg::trace_ctl_t                 ctl_i,
  input  logic [$clog2(TRACE_DEPTH)-1:0]      wr_addr_i,
  input  logic [nxa_pkg::BlkW-1:0]            wr_blk_i,
  input  logic [$clog2(TRACE_DEPTH)-1:0]      nwr_addr_i,
  input  logic [$clog2(TRACE_DEPTH):0]        nwr_next_i,
  input  logic [$clog2(TRACE_DEPTH)-1:0]      rd_addr_i,
  output logic [nxa_pkg::BlkW-1:0]            rd_blk_o,
  output logic [$clog2(TRACE_DEPTH):0]        rd_next_o
);
  import nxa_pkg::*;

  localparam int unsigned AddrW = $clog2(TRACE_DEPTH);

  logic [BlkW-1:0] trace_mem [TRACE_DEPTH];
  logic [AddrW:0]  next_mem  [TRACE_DEPTH];
  logic [BlkW-1:0] rd_blk_q;
  logic [AddrW:0]  rd_next_q;

  // Block identifiers are appended during loading.
  always_ff @(posedge clk_i) begin
    if (ctl_i.trace_wr) begin
      trace_mem[wr_addr_i] <= wr_blk_i;
    end
  end

  // Next position plus one, written by the backward scan; zero means none.
  always_ff @(posedge clk_i) begin
    if (ctl_i.next_wr) begin
      next_mem[nwr_addr_i] <= nwr_next_i;
    end
  end

  // Both stores are read at one address; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_blk_q  <= trace_mem[rd_addr_i];
      rd_next_q <= next_mem[rd_addr_i];
    end
  end

  assign rd_blk_o  = rd_blk_q;
  assign rd_next_o = rd_next_q;

endmodule

@@ rtl/nxa_seen_tbl.sv @@
// Last-seen table: latest scanned position per block, tagged with a generation.
// Depends on nxa_pkg; forwards a write that lands on the entry being read.
module nxa_seen_tbl #(
  parameter int unsigned NUM_BLOCKS  = nxa_pkg::NumBlocksDef,
  parameter int unsigned TRACE_DEPTH = nxa_pkg::TraceDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nxa_pkg::seen_ctl_t                ctl_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     rd_idx_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     wr_idx_i,
  input  logic [$clog2(TRACE_DEPTH)-1:0]    wr_pos_i,
  input  logic [nxa_pkg::EpochW-1:0]        epoch_i,
  output logic                              hit_o,
  output logic [$clog2(TRACE_DEPTH)-1:0]    hit_pos_o
);
  import nxa_pkg::*;

  localparam int unsigned AddrW = $clog2(TRACE_DEPTH);
  localparam int unsigned EntW  = EpochW + AddrW;

  logic [EntW-1:0]  seen_mem [NUM_BLOCKS];
  logic [EntW-1:0]  rd_ent_q;
  logic             fwd_q;
  logic [AddrW-1:0] fwd_pos_q;

  // A clear writes tag zero, which never matches a live generation.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      seen_mem[wr_idx_i] <= '0;
    end else if (ctl_i.wr) begin
      seen_mem[wr_idx_i] <= {epoch_i, wr_pos_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_ent_q <= seen_mem[rd_idx_i];
    end
    fwd_pos_q <= wr_pos_i;
  end

  // The read returns the written value when a write to it lands in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= ctl_i.rd && ctl_i.wr && (rd_idx_i == wr_idx_i);
    end
  end

  assign hit_o     = fwd_q || (rd_ent_q[EntW-1 -: EpochW] == epoch_i);
  assign hit_pos_o = fwd_q ? fwd_pos_q : rd_ent_q[AddrW-1:0];

endmodule

@@ rtl/nxa_ctrl.sv @@
// Sequencer: loading, clearing pass, three-stage backward scan and draining.
// Depends on nxa_pkg; drives the trace store and the last-seen table.
module nxa_ctrl #(
  parameter int unsigned TRACE_DEPTH = nxa_pkg::TraceDepthDef,
  parameter int unsigned NUM_BLOCKS  = nxa_pkg::NumBlocksDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [nxa_pkg::BlkW-1:0]          s_blk_i,
  input  logic                              s_tlast_i,
  input  logic                              s_tuser_i,
  // Output stream.
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [nxa_pkg::OutDataW-1:0]      m_tdata_o,
  output logic                              m_tlast_o,
  output logic                              m_tuser_o,
  // Trace and next-access stores.
  output nxa_pkg::trace_ctl_t               tr_ctl_o,
  output logic [$clog2(TRACE_DEPTH)-1:0]    tr_wr_addr_o,
  output logic [nxa_pkg::BlkW-1:0]          tr_wr_blk_o,
  output logic [$clog2(TRACE_DEPTH)-1:0]    tr_nwr_addr_o,
  output logic [$clog2(TRACE_DEPTH):0]      tr_nwr_next_o,
  output logic [$clog2(TRACE_DEPTH)-1:0]    tr_rd_addr_o,
  input  logic [nxa_pkg::BlkW-1:0]          tr_rd_blk_i,
  input  logic [$clog2(TRACE_DEPTH):0]      tr_rd_next_i,
  // Last-seen table.
  output nxa_pkg::seen_ctl_t                ls_ctl_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]     ls_rd_idx_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]     ls_wr_idx_o,
  output logic [$clog2(TRACE_DEPTH)-1:0]    ls_wr_pos_o,
  output logic [nxa_pkg::EpochW-1:0]        ls_epoch_o,
  input  logic                              ls_hit_i,
  input  logic [$clog2(TRACE_DEPTH)-1:0]    ls_hit_pos_i
);
  import nxa_pkg::*;

  localparam int unsigned AddrW = $clog2(TRACE_DEPTH);
  localparam int unsigned LenW  = AddrW + 1;
  localparam int unsigned IdxW  = $clog2(NUM_BLOCKS);

  nxa_state_e         state_q, state_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    rp_q, rp_d;
  logic               ovf_q, ovf_d;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic [LenW-1:0]    scan_ptr_q, scan_ptr_d;
  logic [IdxW-1:0]    clr_idx_q, clr_idx_d;
  logic               clr_scan_q, clr_scan_d;
  logic               b_vld_q, c_vld_q;
  logic               pend_q, pend_d;
  logic               out_vld_q, out_vld_d;

  logic [AddrW-1:0]    b_pos_q, c_pos_q, pend_pos_q;
  logic [IdxW-1:0]     c_blk_q;
  logic                pend_last_q, pend_ovf_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q, out_ovf_q;

  logic               in_acc;
  logic               load_acc;
  logic               blk_bad;
  logic               full;
  logic               scan_iss;
  logic [AddrW-1:0]   scan_pos;
  logic               drain_acc;
  logic               drain_rec;
  logic               rec_last;
  logic               pend_move;
  logic [NextW-1:0]   next_val;

  // Handshake and decode of the accepted word.
  assign s_tready_o = !pend_q && (state_q == StLoad || state_q == StDrain);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign load_acc   = in_acc && (state_q == StLoad) && (s_tuser_i == ActLoad);
  assign drain_acc  = in_acc && (state_q == StDrain) && (s_tuser_i == ActDrain);
  assign drain_rec  = drain_acc && (rp_q < len_q);
  assign rec_last   = (LenW'(rp_q + 1'b1) == len_q);
  assign blk_bad    = (32'(s_blk_i) >= 32'(NUM_BLOCKS));
  assign full       = (len_q == LenW'(TRACE_DEPTH));

  // Scan issue stage: one trace position per cycle, last to first.
  assign scan_iss = (state_q == StScan) && (scan_ptr_q != '0);
  assign scan_pos = AddrW'(scan_ptr_q - 1'b1);

  // Trace store access.
  always_comb begin
    tr_ctl_o.trace_wr = load_acc && !full && !blk_bad;
    tr_ctl_o.next_wr  = c_vld_q;
    tr_ctl_o.rd       = scan_iss || drain_rec;
  end
  assign tr_wr_addr_o  = len_q[AddrW-1:0];
  assign tr_wr_blk_o   = s_blk_i;
  assign tr_nwr_addr_o = c_pos_q;
  assign tr_nwr_next_o = ls_hit_i ? LenW'(LenW'(ls_hit_pos_i) + 1'b1) : '0;
  assign tr_rd_addr_o  = (state_q == StScan) ? scan_pos : rp_q[AddrW-1:0];

  // Last-seen table access: lookup in stage two, update in stage three.
  always_comb begin
    ls_ctl_o.rd  = b_vld_q;
    ls_ctl_o.wr  = c_vld_q;
    ls_ctl_o.clr = (state_q == StClear);
  end
  assign ls_rd_idx_o = IdxW'(tr_rd_blk_i);
  assign ls_wr_idx_o = (state_q == StClear) ? clr_idx_q : c_blk_q;
  assign ls_wr_pos_o = c_pos_q;
  assign ls_epoch_o  = epoch_q;

  // Pending read moves to the output register once it is free.
  assign pend_move = pend_q && (!out_vld_q || m_tready_i);
  assign out_vld_d = pend_move || (out_vld_q && !m_tready_i);
  assign pend_d    = drain_rec || (pend_q && !pend_move);
  assign next_val  = (tr_rd_next_i == '0) ? '1 : NextW'(tr_rd_next_i);

  // Next state and control registers.
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    rp_d       = rp_q;
    ovf_d      = ovf_q;
    epoch_d    = epoch_q;
    scan_ptr_d = scan_ptr_q;
    clr_idx_d  = clr_idx_q;
    clr_scan_d = clr_scan_q;
    case (state_q)
      StClear: begin
        clr_idx_d = IdxW'(clr_idx_q + 1'b1);
        if (clr_idx_q == IdxW'(NUM_BLOCKS - 1)) begin
          clr_idx_d  = '0;
          epoch_d    = EpochW'(1);
          scan_ptr_d = len_q;
          state_d    = clr_scan_q ? StScan : StLoad;
        end
      end
      StLoad: begin
        if (load_acc) begin
          if (full || blk_bad) begin
            ovf_d = 1'b1;
          end else begin
            len_d = LenW'(len_q + 1'b1);
          end
          if (s_tlast_i) begin
            scan_ptr_d = len_d;
            // A used-up generation tag forces a clearing pass first.
            if (epoch_q == '1) begin
              clr_scan_d = 1'b1;
              state_d    = StClear;
            end else begin
              epoch_d = EpochW'(epoch_q + 1'b1);
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        if (scan_iss) begin
          scan_ptr_d = LenW'(scan_ptr_q - 1'b1);
        end
        if (scan_ptr_q == '0 && !b_vld_q && !c_vld_q) begin
          rp_d    = '0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (drain_acc) begin
          if (!drain_rec || rec_last) begin
            len_d   = '0;
            rp_d    = '0;
            state_d = StLoad;
          end else begin
            rp_d = LenW'(rp_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      len_q      <= '0;
      rp_q       <= '0;
      ovf_q      <= 1'b0;
      epoch_q    <= '0;
      scan_ptr_q <= '0;
      clr_idx_q  <= '0;
      clr_scan_q <= 1'b0;
      b_vld_q    <= 1'b0;
      c_vld_q    <= 1'b0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      rp_q       <= rp_d;
      ovf_q      <= ovf_d;
      epoch_q    <= epoch_d;
      scan_ptr_q <= scan_ptr_d;
      clr_idx_q  <= clr_idx_d;
      clr_scan_q <= clr_scan_d;
      b_vld_q    <= scan_iss;
      c_vld_q    <= b_vld_q;
      pend_q     <= pend_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Scan pipeline, pending record and output word payloads.
  always_ff @(posedge clk_i) begin
    b_pos_q <= scan_pos;
    c_pos_q <= b_pos_q;
    c_blk_q <= IdxW'(tr_rd_blk_i);
    if (drain_rec) begin
      pend_pos_q  <= rp_q[AddrW-1:0];
      pend_last_q <= rec_last;
      pend_ovf_q  <= ovf_q;
    end
    if (pend_move) begin
      out_data_q <= OutDataW'({next_val, tr_rd_blk_i, PosW'(pend_pos_q)});
      out_last_q <= pend_last_q;
      out_ovf_q  <= pend_ovf_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_ovf_q;

endmodule

@@ rtl/next_access_annotator_top.sv @@
// Loads: one word per cycle while no result is pending. End-of-trace scan: one
// position per cycle through trace read, last-seen lookup and write back.
// Drains: a request is read into a pending record that moves to the output
// register once free; no request is taken while one is pending. Reset is
// asynchronous and active low; afterwards a clearing pass sweeps the last-seen
// table with s_axis_tready_o low; the same pass runs before every 255th trace's scan.
module next_access_annotator_top #(
  parameter int unsigned TRACE_DEPTH = nxa_pkg::TraceDepthDef,
  parameter int unsigned NUM_BLOCKS  = nxa_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [nxa_pkg::InDataW-1:0]   s_axis_tdata_i,   // [11:0] block_id, [15:12] zero
  input  logic                          s_axis_tlast_i,   // end_of_trace
  input  logic                          s_axis_tuser_i,   // action
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [nxa_pkg::OutDataW-1:0]  m_axis_tdata_o,   // [11:0] position, [23:12] obj_id,
                                                          // [37:24] next_access, [39:38] zero
  output logic                          m_axis_tlast_o,   // last_record
  output logic                          m_axis_tuser_o    // overflow
);
  import nxa_pkg::*;

  localparam int unsigned AddrW = $clog2(TRACE_DEPTH);
  localparam int unsigned IdxW  = $clog2(NUM_BLOCKS);

  trace_ctl_t       tr_ctl;
  logic [AddrW-1:0] tr_wr_addr, tr_nwr_addr, tr_rd_addr;
  logic [BlkW-1:0]  tr_wr_blk, tr_rd_blk;
  logic [AddrW:0]   tr_nwr_next, tr_rd_next;

  seen_ctl_t         ls_ctl;
  logic [IdxW-1:0]   ls_rd_idx, ls_wr_idx;
  logic [AddrW-1:0]  ls_wr_pos, ls_hit_pos;
  logic [EpochW-1:0] ls_epoch;
  logic              ls_hit;

  // Sequencer and stream ports.
  nxa_ctrl #(
    .TRACE_DEPTH (TRACE_DEPTH),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_o    (s_axis_tready_o),
    .s_blk_i       (s_axis_tdata_i[BlkW-1:0]),
    .s_tlast_i     (s_axis_tlast_i),
    .s_tuser_i     (s_axis_tuser_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tlast_o     (m_axis_tlast_o),
    .m_tuser_o     (m_axis_tuser_o),
    .tr_ctl_o      (tr_ctl),
    .tr_wr_addr_o  (tr_wr_addr),
    .tr_wr_blk_o   (tr_wr_blk),
    .tr_nwr_addr_o (tr_nwr_addr),
    .tr_nwr_next_o (tr_nwr_next),
    .tr_rd_addr_o  (tr_rd_addr),
    .tr_rd_blk_i   (tr_rd_blk),
    .tr_rd_next_i  (tr_rd_next),
    .ls_ctl_o      (ls_ctl),
    .ls_rd_idx_o   (ls_rd_idx),
    .ls_wr_idx_o   (ls_wr_idx),
    .ls_wr_pos_o   (ls_wr_pos),
    .ls_epoch_o    (ls_epoch),
    .ls_hit_i      (ls_hit),
    .ls_hit_pos_i  (ls_hit_pos)
  );

  // Trace and next-access stores.
  nxa_trace_store #(
    .TRACE_DEPTH (TRACE_DEPTH)
  ) u_trace_store (
    .clk_i      (clk_i),
    .ctl_i      (tr_ctl),
    .wr_addr_i  (tr_wr_addr),
    .wr_blk_i   (tr_wr_blk),
    .nwr_addr_i (tr_nwr_addr),
    .nwr_next_i (tr_nwr_next),
    .rd_addr_i  (tr_rd_addr),
    .rd_blk_o   (tr_rd_blk),
    .rd_next_o  (tr_rd_next)
  );

  // Last-seen table.
  nxa_seen_tbl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .TRACE_DEPTH (TRACE_DEPTH)
  ) u_seen_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ls_ctl),
    .rd_idx_i  (ls_rd_idx),
    .wr_idx_i  (ls_wr_idx),
    .wr_pos_i  (ls_wr_pos),
    .epoch_i   (ls_epoch),
    .hit_o     (ls_hit),
    .hit_pos_o (ls_hit_pos)
  );

endmodule

@@ rtl/nxa_checker.sv @@
// Port-level checks for the next-access annotator, bound to the top level.
// Sees only the top-level ports; needs no package.
module nxa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  logic [11:0] exp_pos_q;
  logic        ovf_seen_q;
  logic        out_acc;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Records run from position zero upward and restart after the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q  <= '0;
      ovf_seen_q <= 1'b0;
    end else if (out_acc) begin
      exp_pos_q  <= m_axis_tlast_o ? 12'd0 : 12'(m_axis_tdata_o[11:0] + 12'd1);
      ovf_seen_q <= ovf_seen_q || m_axis_tuser_o;
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // Positions come out in forward order without gaps.
  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[11:0] == exp_pos_q)
    else $error("record position out of order");

  // The overflow flag never drops once reported.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ovf_seen_q |-> m_axis_tuser_o)
    else $error("overflow flag dropped");

  // A next access lies strictly after the current position.
  a_next_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[37:24] == 14'h3FFF)
      || (m_axis_tdata_o[37:24] > 14'(m_axis_tdata_o[11:0]) + 14'd1))
    else $error("next access not after current position");

endmodule

bind next_access_annotator_top nxa_checker u_nxa_checker (.*);
